// File: rtl/bfc_pkg.sv
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared types, constants and letter helpers for the Beaufort cipher stream.
// ----------------------------------------------------------------------------
package bfc_pkg;

  // Key store geometry: fixed by the width of the key registers.
  localparam int KEY_BYTES   = 32;
  localparam int KEY_MAX_DEF = 32;
  localparam int LEN_W       = 6;
  localparam int POS_W       = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_W0     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_W1     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_W2     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_W3     = 3'd4;

  localparam logic [7:0] CHAR_UA = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_UZ = 8'h5A;  // 'Z'
  localparam logic [7:0] CHAR_LA = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LZ = 8'h7A;  // 'z'
  localparam logic [5:0] ALPHA_N = 6'd26;

  // Controller to datapath.
  typedef struct packed {
    logic start;   // latch the accepted item and seed the key search
    logic step;    // advance the key search by one byte
    logic finish;  // load the output register and commit the key position
  } bfc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic found;      // key byte under the search pointer is a letter
    logic exhausted;  // every key byte in use was tried (or no key)
  } bfc_sts_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= CHAR_UA) && (c <= CHAR_UZ);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= CHAR_LA) && (c <= CHAR_LZ);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return is_upper(c) || is_lower(c);
  endfunction

  // Alphabet index 0..25; only meaningful for letters.
  function automatic logic [4:0] letter_idx(input logic [7:0] c);
    logic [7:0] d;
    d = is_upper(c) ? (c - CHAR_UA) : (c - CHAR_LA);
    return d[4:0];
  endfunction

endpackage

// File: rtl/bfc_ctrl.sv
// ----------------------------------------------------------------------------
// bfc_ctrl
// Sequencer for one item at a time: accept, key search, output handoff.
// ----------------------------------------------------------------------------
module bfc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  bfc_pkg::bfc_sts_t sts_i,
  output bfc_pkg::bfc_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_HOLD   = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       done;

  assign out_free = !out_valid_q || !out_stall_i;
  assign done     = sts_i.exhausted || sts_i.found;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (!done) begin
          cmd_o.step = 1'b1;
        end else if (out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.finish ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/bfc_datapath.sv
// ----------------------------------------------------------------------------
// bfc_datapath
// Key registers, key search pointer, cipher arithmetic and output register.
// ----------------------------------------------------------------------------
module bfc_datapath #(
  parameter int KEY_MAX = bfc_pkg::KEY_MAX_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bfc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bfc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic [7:0]                       text_byte_i,
  input  logic                             message_start_i,
  input  bfc_pkg::bfc_cmd_t                cmd_i,
  output bfc_pkg::bfc_sts_t                sts_o,
  output logic [7:0]                       result_byte_o,
  output logic                             key_invalid_o
);

  localparam logic [bfc_pkg::LEN_W-1:0] KeyMaxL = bfc_pkg::LEN_W'(KEY_MAX);

  logic [bfc_pkg::KEY_BYTES-1:0][7:0] key_q;
  logic [bfc_pkg::LEN_W-1:0]          key_len_q;
  logic [bfc_pkg::LEN_W-1:0]          len_eff;

  logic [bfc_pkg::POS_W-1:0] pos_q, ptr_q, ptr_d, ptr_nx, ptr_init;
  logic [bfc_pkg::LEN_W-1:0] cnt_q, cnt_d;
  logic [7:0]                text_q;
  logic [7:0]                out_byte_q;
  logic                      out_inv_q;

  logic [7:0] key_byte;
  logic       text_letter;
  logic [5:0] diff;
  logic [5:0] vsum;
  logic [7:0] cipher_byte;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= '0;
      key_len_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bfc_pkg::CFG_KEY_LENGTH: key_len_q     <= cfg_wdata_i[bfc_pkg::LEN_W-1:0];
        bfc_pkg::CFG_KEY_W0:     key_q[7:0]    <= cfg_wdata_i;
        bfc_pkg::CFG_KEY_W1:     key_q[15:8]   <= cfg_wdata_i;
        bfc_pkg::CFG_KEY_W2:     key_q[23:16]  <= cfg_wdata_i;
        bfc_pkg::CFG_KEY_W3:     key_q[31:24]  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign len_eff = (key_len_q > KeyMaxL) ? KeyMaxL : key_len_q;

  // Key search.
  assign key_byte = key_q[ptr_q];
  assign ptr_nx   = ((bfc_pkg::LEN_W'(ptr_q) + 1'b1) == len_eff) ? '0 : (ptr_q + 1'b1);
  assign ptr_init = (message_start_i || (bfc_pkg::LEN_W'(pos_q) >= len_eff)) ? '0 : pos_q;

  assign sts_o.found     = bfc_pkg::is_letter(key_byte);
  assign sts_o.exhausted = (cnt_q == len_eff);

  always_comb begin
    ptr_d = ptr_q;
    cnt_d = cnt_q;
    if (cmd_i.start) begin
      ptr_d = ptr_init;
      cnt_d = '0;
    end else if (cmd_i.step) begin
      ptr_d = ptr_nx;
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    cnt_q <= cnt_d;
    if (cmd_i.start) begin
      text_q <= text_byte_i;
    end
  end

  // Cipher: (key - letter) mod 26, case taken from the text byte.
  assign text_letter = bfc_pkg::is_letter(text_q);
  assign diff        = {1'b0, bfc_pkg::letter_idx(key_byte)} + bfc_pkg::ALPHA_N
                       - {1'b0, bfc_pkg::letter_idx(text_q)};
  assign vsum        = (diff >= bfc_pkg::ALPHA_N) ? (diff - bfc_pkg::ALPHA_N) : diff;
  assign cipher_byte = (bfc_pkg::is_upper(text_q) ? bfc_pkg::CHAR_UA : bfc_pkg::CHAR_LA)
                       + {2'b00, vsum};

  // Key position: cleared at message start, advanced past the used key letter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (cmd_i.start && message_start_i) begin
      pos_q <= '0;
    end else if (cmd_i.finish && !sts_o.exhausted && text_letter) begin
      pos_q <= ptr_nx;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_inv_q <= sts_o.exhausted;
      if (sts_o.exhausted) begin
        out_byte_q <= '0;
      end else if (text_letter) begin
        out_byte_q <= cipher_byte;
      end else begin
        out_byte_q <= text_q;
      end
    end
  end

  assign result_byte_o = out_byte_q;
  assign key_invalid_o = out_inv_q;

endmodule

// File: rtl/beaufort_cipher_stream.sv
// ----------------------------------------------------------------------------
// beaufort_cipher_stream
// Byte stream Beaufort cipher (self-inverse) with a configurable ASCII key.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one text byte and a
//   message_start flag per transfer; message_start rewinds the key to its
//   first letter. Output channel (out_valid_o / out_stall_i) carries the
//   result byte and key_invalid. Every input transfer yields one output.
//   Key registers are written through cfg_we_i / cfg_index_i / cfg_wdata_i
//   while the block is idle: index 0 is key_length, 1..4 the key words.
//   Timing: the key search walks one key byte per cycle from the current
//   key position until it hits a letter, so an item finishes soonest when
//   the key byte at the position is a letter and takes longer when
//   non-letter key bytes must be skipped; it walks every key byte in use
//   when the key holds no letter at all. The search loop sets the rate;
//   one item is in flight at a time.
//   The output register lets the next item be taken while a result still
//   waits; if out_stall_i holds, a finished search waits in place and the
//   input stays stalled. Reset clears the key registers, the key position
//   and the output valid flag.
// ----------------------------------------------------------------------------
module beaufort_cipher_stream #(
  parameter int KEY_MAX = bfc_pkg::KEY_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [bfc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bfc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     text_byte_i,
  input  logic                           message_start_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     result_byte_o,
  output logic                           key_invalid_o
);

  bfc_pkg::bfc_cmd_t cmd;
  bfc_pkg::bfc_sts_t sts;

  // Sequencer: accept, search, hand off.
  bfc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Key store, search pointer and cipher arithmetic.
  bfc_datapath #(
    .KEY_MAX (KEY_MAX)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .text_byte_i     (text_byte_i),
    .message_start_i (message_start_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .result_byte_o   (result_byte_o),
    .key_invalid_o   (key_invalid_o)
  );

endmodule

// File: rtl/bfc_checker.sv
// ----------------------------------------------------------------------------
// bfc_checker
// Port-level checks for the Beaufort cipher stream, bound to the top level.
// ----------------------------------------------------------------------------
module bfc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] result_byte_o,
  input logic       key_invalid_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_byte_o)
      && $stable(key_invalid_o))
    else $error("stalled result changed or dropped");

  // Drive a zero byte with an invalid key.
  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && key_invalid_o |-> result_byte_o == 8'h00)
    else $error("key_invalid result with nonzero byte");

  // Take one item at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken during search");

  // Release the input only with a fresh result in the output register.
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("input released without a result");

endmodule

bind beaufort_cipher_stream bfc_checker u_bfc_checker (.*);

// File: tb/beaufort_cipher_stream_tb.sv
// ----------------------------------------------------------------------------
// beaufort_cipher_stream_tb
// Self-checking bench for the Beaufort byte stream. A scoreboard class keeps
// its own copy of the key registers and key position and predicts one result
// per input transfer. Plain tasks drive a short directed set (letter bounds,
// pass-through bytes, empty, clamped and letterless keys, and a key length
// cut below the current position) and then about a thousand random message
// bytes under changing keys, with random idling and stalling on both sides.
// ----------------------------------------------------------------------------
module beaufort_cipher_stream_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_LIMIT   = bfc_pkg::KEY_MAX_DEF;
  localparam int ITEM_TARGET = 1000;
  localparam int CYCLE_LIMIT = 1_000_000;
  // Worst-case search plus output register, with margin.
  localparam int SETTLE      = bfc_pkg::KEY_MAX_DEF + 8;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_PCT    = 18;

  typedef struct packed {
    logic [7:0] text;
    logic       bad_key;
  } cipher_out_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the key state, predicts each result, checks in order.
  // --------------------------------------------------------------------------
  class beaufort_scoreboard;
    logic [bfc_pkg::LEN_W-1:0] key_len;
    logic [63:0]               key_word [4];
    logic [bfc_pkg::POS_W-1:0] key_pos;
    cipher_out_t               expected_q [$];
    int                        mismatches;

    function new();
      key_len = '0;
      foreach (key_word[i]) key_word[i] = '0;
      key_pos    = '0;
      mismatches = 0;
    endfunction

    function bit is_alpha(logic [7:0] c);
      return (c >= bfc_pkg::CHAR_UA && c <= bfc_pkg::CHAR_UZ) ||
             (c >= bfc_pkg::CHAR_LA && c <= bfc_pkg::CHAR_LZ);
    endfunction

    function int alpha_index(logic [7:0] c);
      return (c <= bfc_pkg::CHAR_UZ) ? int'(c - bfc_pkg::CHAR_UA)
                                     : int'(c - bfc_pkg::CHAR_LA);
    endfunction

    function logic [7:0] key_char(int i);
      logic [63:0] w;
      w = key_word[i / 8] >> (8 * (i % 8));
      return w[7:0];
    endfunction

    function void configure(logic [bfc_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
      case (idx)
        bfc_pkg::CFG_KEY_LENGTH: key_len = data[bfc_pkg::LEN_W-1:0];
        bfc_pkg::CFG_KEY_W0:     key_word[0] = data;
        bfc_pkg::CFG_KEY_W1:     key_word[1] = data;
        bfc_pkg::CFG_KEY_W2:     key_word[2] = data;
        bfc_pkg::CFG_KEY_W3:     key_word[3] = data;
        default: ;  // unmapped index: no register behind it
      endcase
    endfunction

    function void note_input(logic [7:0] text, logic start);
      int          len;
      int          p;
      int          k;
      int          n;
      bit          usable;
      cipher_out_t r;
      if (start) key_pos = '0;
      len = (key_len > KEY_LIMIT) ? KEY_LIMIT : int'(key_len);
      usable = 1'b0;
      for (n = 0; n < len; n++) if (is_alpha(key_char(n))) usable = 1'b1;
      if (!usable) begin
        r.text    = 8'h00;
        r.bad_key = 1'b1;
      end else if (!is_alpha(text)) begin
        r.text    = text;
        r.bad_key = 1'b0;
      end else begin
        // A position past a shortened key restarts at byte 0.
        p = (key_pos < len) ? int'(key_pos) : 0;
        for (n = 0; n < len && !is_alpha(key_char(p)); n++) p = (p + 1) % len;
        k = alpha_index(key_char(p));
        r.bad_key = 1'b0;
        r.text    = ((text <= bfc_pkg::CHAR_UZ) ? bfc_pkg::CHAR_UA : bfc_pkg::CHAR_LA) +
                    8'((k + bfc_pkg::ALPHA_N - alpha_index(text)) % bfc_pkg::ALPHA_N);
        key_pos   = bfc_pkg::POS_W'((p + 1) % len);
      end
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_result(logic [7:0] text, logic bad_key);
      cipher_out_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual byte %h key_invalid %b",
                 $time, text, bad_key);
        return;
      end
      want = expected_q.pop_front();
      if (text !== want.text) begin
        mismatches++;
        $display("%0t: result_byte mismatch: expected %h actual %h",
                 $time, want.text, text);
      end
      if (bad_key !== want.bad_key) begin
        mismatches++;
        $display("%0t: key_invalid mismatch: expected %b actual %b",
                 $time, want.bad_key, bad_key);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals: every block input starts at a known value.
  // --------------------------------------------------------------------------
  logic                           clk_i;
  logic                           rst_ni          = 1'b0;
  logic                           cfg_we_i        = 1'b0;
  logic [bfc_pkg::CFG_IDX_W-1:0]  cfg_index_i     = '0;
  logic [bfc_pkg::CFG_DATA_W-1:0] cfg_wdata_i     = '0;
  logic                           in_valid_i      = 1'b0;
  logic                           in_stall_o;
  logic [7:0]                     text_byte_i     = '0;
  logic                           message_start_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i     = 1'b0;
  logic [7:0]                     result_byte_o;
  logic                           key_invalid_o;

  beaufort_scoreboard sb;

  // Knobs shared between the stimulus and the receiver process.
  int src_idle_pct  = IDLE_PCT;
  int sink_idle_pct = IDLE_PCT;
  bit hold_req      = 1'b0;
  int sent          = 0;
  int cycles        = 0;

  beaufort_cipher_stream DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .text_byte_i     (text_byte_i),
    .message_start_i (message_start_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_byte_o   (result_byte_o),
    .key_invalid_o   (key_invalid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: stall at random, or hold off for a long stretch on request so
  // the block fills up and pushes back on its input.
  initial begin : sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < sink_idle_pct);
      end
    end
  end

  // Monitor: sample mid-cycle, where valid and stall are settled; a transfer
  // seen here completes at the next rising edge.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(result_byte_o, key_invalid_o);
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // Offer one byte, idling first at random; hold the payload until the
  // transfer, then note it for prediction.
  task automatic send_text(input logic [7:0] text, input logic start);
    bit taken;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    text_byte_i     <= text;
    message_start_i <= start;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    sb.note_input(text, start);
    sent++;
  endtask

  // Drop valid and wait until every expected result is out, then let the
  // block settle before anything touches the key.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write one register; the caller drops the write enable after a group.
  task automatic write_reg(input logic [bfc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.configure(idx, data);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = $urandom_range(1) ? bfc_pkg::CHAR_UA : bfc_pkg::CHAR_LA;
    return base + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_other();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (sb.is_alpha(c));
    return c;
  endfunction

  // Key word styles: 0 mostly letters, 1 raw bits, 2 no letters at all.
  function automatic logic [63:0] rand_key_word(input int style);
    logic [63:0] w;
    int          b;
    if (style == 1) return {$urandom(), $urandom()};
    for (b = 0; b < 8; b++)
      w[8*b +: 8] = (style == 0 && $urandom_range(99) < 80) ? rand_letter() : rand_other();
    return w;
  endfunction

  // One random phase: new key settings, then a run of messages.
  task automatic random_phase(input int phase_no);
    int          n;
    int          i;
    int          w;
    int          len;
    int          style;
    int          msg_left;
    logic [63:0] data;
    logic [7:0]  text;
    logic        start;
    drain();
    // Length: mostly in range, sometimes empty, full or above the maximum.
    if ($urandom_range(99) < 70) begin
      case ($urandom_range(9))
        0:       len = 0;
        1:       len = 1;
        2:       len = KEY_LIMIT;
        3:       len = (1 << bfc_pkg::LEN_W) - 1;
        4:       len = $urandom_range(KEY_LIMIT + 1, (1 << bfc_pkg::LEN_W) - 1);
        default: len = $urandom_range(2, KEY_LIMIT);
      endcase
      data = {$urandom(), $urandom()};
      data[bfc_pkg::LEN_W-1:0] = bfc_pkg::LEN_W'(len);
      write_reg(bfc_pkg::CFG_KEY_LENGTH, data);
    end
    case ($urandom_range(9))
      0:       style = 1;
      1:       style = 2;
      default: style = 0;
    endcase
    for (w = 0; w < 4; w++)
      if ($urandom_range(99) < 75)
        write_reg(bfc_pkg::CFG_IDX_W'(bfc_pkg::CFG_KEY_W0 + w), rand_key_word(style));
    // Writes to unmapped indexes must not disturb anything.
    if ($urandom_range(9) == 0)
      write_reg(bfc_pkg::CFG_IDX_W'($urandom_range(bfc_pkg::CFG_KEY_W3 + 1,
                                                   (1 << bfc_pkg::CFG_IDX_W) - 1)),
                {$urandom(), $urandom()});
    cfg_we_i <= 1'b0;

    // Phase 3 runs a long stretch with no idling on either side.
    src_idle_pct  = (phase_no == 3) ? 0 : IDLE_PCT;
    sink_idle_pct = (phase_no == 3) ? 0 : IDLE_PCT;
    if (phase_no == 2) hold_req = 1'b1;

    n        = (phase_no == 3) ? 150 : $urandom_range(30, 70);
    msg_left = 0;
    for (i = 0; i < n; i++) begin
      // A phase may open mid-message, keeping the old key position.
      if (msg_left == 0) begin
        msg_left = $urandom_range(1, 24);
        start    = (i != 0) || ($urandom_range(3) != 0);
      end else begin
        start = 1'b0;
      end
      msg_left--;
      text = ($urandom_range(99) < 85) ? rand_letter() : 8'($urandom_range(255));
      // Once, pause the sender until the block has fully drained.
      if (phase_no == 5 && i == n / 2) drain();
      send_text(text, start);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0] probe_text [12];
    int         i;
    int         phase_no;
    probe_text = '{bfc_pkg::CHAR_UA, bfc_pkg::CHAR_UZ, bfc_pkg::CHAR_LA, bfc_pkg::CHAR_LZ,
                   8'h00, 8'hFF,
                   bfc_pkg::CHAR_UA - 8'd1, bfc_pkg::CHAR_UZ + 8'd1,
                   bfc_pkg::CHAR_LA - 8'd1, bfc_pkg::CHAR_LZ + 8'd1,
                   "M", "m"};
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Key empty after reset: every byte flags an invalid key.
    send_text(bfc_pkg::CHAR_UA, 1'b1);
    send_text(8'hFF, 1'b0);
    drain();

    // Key "a1Z?": both cases, non-letters skipped, wrap after two letters.
    write_reg(bfc_pkg::CFG_KEY_LENGTH, 64'd4);
    write_reg(bfc_pkg::CFG_KEY_W0, {32'h0, "?Z1a"});
    write_reg(bfc_pkg::CFG_KEY_W1, {$urandom(), $urandom()});
    write_reg(bfc_pkg::CFG_KEY_W2, {$urandom(), $urandom()});
    write_reg(bfc_pkg::CFG_KEY_W3, {$urandom(), $urandom()});
    write_reg(bfc_pkg::CFG_KEY_W3 + 3'd1, {$urandom(), $urandom()});
    cfg_we_i <= 1'b0;
    for (i = 0; i < 12; i++) send_text(probe_text[i], i == 0);
    drain();

    // Length above the maximum clamps; the only letter is the last key byte,
    // so every letter walks the whole key.
    write_reg(bfc_pkg::CFG_KEY_LENGTH, 64'd63);
    write_reg(bfc_pkg::CFG_KEY_W0, {8{"0"}});
    write_reg(bfc_pkg::CFG_KEY_W1, {8{"0"}});
    write_reg(bfc_pkg::CFG_KEY_W2, {8{"0"}});
    write_reg(bfc_pkg::CFG_KEY_W3, {"q", {7{"."}}});
    cfg_we_i <= 1'b0;
    send_text("q", 1'b1);
    send_text("Q", 1'b0);
    drain();

    // Key bytes in use hold no letter: invalid for letters and others alike.
    write_reg(bfc_pkg::CFG_KEY_LENGTH, 64'd5);
    cfg_we_i <= 1'b0;
    send_text("b", 1'b1);
    send_text("#", 1'b0);
    drain();

    // Shorten the key below the live position mid-message: restart at byte 0.
    write_reg(bfc_pkg::CFG_KEY_LENGTH, 64'd8);
    write_reg(bfc_pkg::CFG_KEY_W0, "KEYWORDS");
    cfg_we_i <= 1'b0;
    for (i = 0; i < 5; i++) send_text(rand_letter(), i == 0);
    drain();
    write_reg(bfc_pkg::CFG_KEY_LENGTH, 64'd3);
    cfg_we_i <= 1'b0;
    send_text(rand_letter(), 1'b0);
    send_text(rand_letter(), 1'b0);

    // Random messages under changing keys.
    phase_no = 0;
    while (sent < ITEM_TARGET) begin
      random_phase(phase_no);
      phase_no++;
    end

    drain();
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
